@@ src/mot_pkg.sv @@
// ----------------------------------------------------------------------------
// mot_pkg
// Shared types and constants for the mailbox ownership table.
// ----------------------------------------------------------------------------
package mot_pkg;

  localparam int MAILBOXES_DEF = 64;
  localparam int SLOTS_DEF     = 5;
  localparam int PROCESSES_DEF = 16;

  localparam int PID_W  = 4;
  localparam int NUM_W  = 7;
  localparam int MBX_W  = 6;
  localparam int STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_NUMBER = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE_FREE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_IN_USE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_SLOTS_FULL = 3'd4;

  typedef enum logic {
    CMP_FREE  = 1'b0,
    CMP_OWNED = 1'b1
  } cmp_mode_t;

  typedef struct packed {
    cmp_mode_t        mode;
    logic             valid;
    logic [PID_W-1:0] owner;
    logic [PID_W-1:0] pid;
  } cmp_req_t;

endpackage

@@ src/mot_owner_mem.sv @@
// ----------------------------------------------------------------------------
// mot_owner_mem
// Owner id store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mot_owner_mem #(
  parameter int MAILBOXES = mot_pkg::MAILBOXES_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(MAILBOXES)-1:0]   waddr,
  input  logic [mot_pkg::PID_W-1:0]      wdata,
  input  logic [$clog2(MAILBOXES)-1:0]   raddr,
  output logic [mot_pkg::PID_W-1:0]      rdata
);

  logic [mot_pkg::PID_W-1:0] mem [MAILBOXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/mot_cmp.sv @@
// ----------------------------------------------------------------------------
// mot_cmp
// Shared entry test: free entry, or entry owned by the requesting process.
// ----------------------------------------------------------------------------
module mot_cmp (
  input  mot_pkg::cmp_req_t req,
  output logic              hit
);

  always_comb begin
    case (req.mode)
      mot_pkg::CMP_FREE:  hit = !req.valid;
      mot_pkg::CMP_OWNED: hit = req.valid && (req.owner == req.pid);
      default:            hit = 1'b0;
    endcase
  end

endmodule

@@ src/mailbox_ownership_table_top.sv @@
// ----------------------------------------------------------------------------
// mailbox_ownership_table_top
// Bind / unbind requests against a mailbox owner table with per-process limits.
// ----------------------------------------------------------------------------
// Sequence, accept to result valid: a check state settles a bad number and a
// named bind; a named unbind adds an unbind check state; bind-any and
// unbind-all scan the table. The scans walk the owner table one entry per cycle
// through one compare unit.
// One transaction in flight; a new request is taken once the result is queued.
// Sync reset clears all owner valid bits and slot counts at once; no sweep.
module mailbox_ownership_table_top #(
  parameter int MAILBOXES         = mot_pkg::MAILBOXES_DEF,
  parameter int SLOTS_PER_PROCESS = mot_pkg::SLOTS_DEF,
  parameter int PROCESSES         = mot_pkg::PROCESSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] process_id, [10:4] req_mbx
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [8:3] mailbox
);

  localparam int IW  = $clog2(MAILBOXES);
  localparam int NPR = (PROCESSES < (2 ** mot_pkg::PID_W)) ? PROCESSES
                                                          : (2 ** mot_pkg::PID_W);
  localparam int PW  = (NPR > 1) ? $clog2(NPR) : 1;
  localparam int CW  = $clog2(SLOTS_PER_PROCESS + 1);
  localparam logic [IW-1:0] LAST = IW'(MAILBOXES - 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_CHECK     = 7'b0000010,
    S_SCAN_FREE = 7'b0000100,
    S_UNB_CHK   = 7'b0001000,
    S_SCAN_ALL  = 7'b0010000,
    S_DRAIN     = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  state_t                        state;
  logic                          kind_q;
  logic [mot_pkg::PID_W-1:0]     pid_q;
  logic [mot_pkg::NUM_W-1:0]     num_q;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 rd_idx_q;
  logic                          rd_live_q;
  logic [MAILBOXES-1:0]          owner_valid;
  logic [CW-1:0]                 cnt [NPR];
  logic [mot_pkg::STAT_W-1:0]    res_status;
  logic [mot_pkg::MBX_W-1:0]     res_mbox;

  logic                          bad;
  logic [PW-1:0]                 pid_idx;
  logic [CW-1:0]                 cnt_cur;
  logic                          full;
  logic [IW-1:0]                 cmp_idx;
  logic [mot_pkg::PID_W-1:0]     rdata;
  mot_pkg::cmp_req_t             cmp_req;
  logic                          hit;
  logic                          commit;

  assign s_tready = (state == S_IDLE);

  assign bad     = (32'(num_q) >= MAILBOXES) || (32'(pid_q) >= PROCESSES);
  assign pid_idx = PW'(pid_q);
  assign cnt_cur = cnt[pid_idx];
  assign full    = 32'(cnt_cur) >= SLOTS_PER_PROCESS;
  assign cmp_idx = ((state == S_SCAN_ALL) || (state == S_DRAIN)) ? rd_idx_q : idx;

  always_comb begin
    cmp_req.mode  = kind_q ? mot_pkg::CMP_OWNED : mot_pkg::CMP_FREE;
    cmp_req.valid = owner_valid[cmp_idx];
    cmp_req.owner = rdata;
    cmp_req.pid   = pid_q;
  end

  // bind takes effect only here
  assign commit = ((state == S_CHECK) && !bad && !kind_q && (num_q != '0) && hit && !full)
               || ((state == S_SCAN_FREE) && hit && !full);

  mot_cmp u_cmp (
    .req (cmp_req),
    .hit (hit)
  );

  mot_owner_mem #(
    .MAILBOXES (MAILBOXES)
  ) u_owner_mem (
    .clk   (clk),
    .we    (commit),
    .waddr (idx),
    .wdata (pid_q),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      owner_valid <= '0;
      rd_live_q   <= 1'b0;
      m_tvalid    <= 1'b0;
      for (int p = 0; p < NPR; p++) begin
        cnt[p] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      if (commit) begin
        owner_valid[idx] <= 1'b1;
        cnt[pid_idx]     <= cnt_cur + CW'(1);
        res_status       <= mot_pkg::ST_OK;
        res_mbox         <= mot_pkg::MBX_W'(idx);
        state            <= S_RESP;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_q <= s_tuser;
            pid_q  <= s_tdata[3:0];
            num_q  <= s_tdata[10:4];
            idx    <= IW'(s_tdata[10:4]);
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          rd_live_q <= 1'b0;
          if (bad) begin
            res_status <= mot_pkg::ST_BAD_NUMBER;
            res_mbox   <= '0;
            state      <= S_RESP;
          end else if (!kind_q) begin
            if (num_q == '0) begin
              idx   <= IW'(1);
              state <= S_SCAN_FREE;
            end else if (!hit) begin
              res_status <= mot_pkg::ST_IN_USE;
              res_mbox   <= '0;
              state      <= S_RESP;
            end else if (full) begin
              res_status <= mot_pkg::ST_SLOTS_FULL;
              res_mbox   <= '0;
              state      <= S_RESP;
            end
          end else if (num_q == '0) begin
            cnt[pid_idx] <= '0;
            idx          <= IW'(1);
            state        <= S_SCAN_ALL;
          end else begin
            state <= S_UNB_CHK;
          end
        end
        S_SCAN_FREE: begin
          if (hit) begin
            if (full) begin
              res_status <= mot_pkg::ST_SLOTS_FULL;
              res_mbox   <= '0;
              state      <= S_RESP;
            end
          end else if (idx == LAST) begin
            res_status <= mot_pkg::ST_NONE_FREE;
            res_mbox   <= '0;
            state      <= S_RESP;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_UNB_CHK: begin
          res_status <= hit ? mot_pkg::ST_OK : mot_pkg::ST_IN_USE;
          res_mbox   <= hit ? mot_pkg::MBX_W'(idx) : '0;
          if (hit) begin
            owner_valid[idx] <= 1'b0;
            cnt[pid_idx]     <= cnt_cur - CW'(1);
          end
          state <= S_RESP;
        end
        S_SCAN_ALL: begin
          // read data trails the issued index through the registered read port
          rd_live_q <= 1'b1;
          rd_idx_q  <= idx;
          if (rd_live_q && hit) begin
            owner_valid[rd_idx_q] <= 1'b0;
          end
          if (idx == LAST) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_DRAIN: begin
          if (rd_live_q && hit) begin
            owner_valid[rd_idx_q] <= 1'b0;
          end
          rd_live_q  <= 1'b0;
          res_status <= mot_pkg::ST_OK;
          res_mbox   <= '0;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, res_mbox, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_CHECK)
    else $error("accepted request did not start a check");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> !owner_valid[idx])
    else $error("bind committed onto an owned mailbox");

  a_commit_owned: assert property (@(posedge clk) disable iff (rst)
    commit |=> owner_valid[$past(idx)])
    else $error("bound mailbox not marked owned");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= mot_pkg::ST_SLOTS_FULL)
    else $error("status code out of range");

  a_error_mbox_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != mot_pkg::ST_OK) |-> m_tdata[8:3] == '0)
    else $error("error result carries a mailbox number");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mailbox ownership table. Bind/unbind requests go
// in on the slave stream, one status/mailbox reply per request comes back on
// the master stream. A shadow owner table and slot list predict every reply.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_MBX          = mot_pkg::MAILBOXES_DEF;
  localparam int N_SLOTS        = mot_pkg::SLOTS_DEF;
  localparam int N_PROC         = mot_pkg::PROCESSES_DEF;
  localparam int N_RANDOM       = 1600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;

  localparam logic KIND_BIND   = 1'b0;
  localparam logic KIND_UNBIND = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [mot_pkg::PID_W-1:0] pid;
    logic [mot_pkg::NUM_W-1:0] num;
  } request_t;

  typedef struct packed {
    logic [mot_pkg::STAT_W-1:0] status;
    logic [mot_pkg::MBX_W-1:0]  mbx;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [3:0] process_id, [10:4] req_mbx
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [2:0] status, [8:3] mailbox

  mailbox_ownership_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow state
  logic                      own_valid [N_MBX];
  logic [mot_pkg::PID_W-1:0] own_pid   [N_MBX];
  logic [mot_pkg::MBX_W-1:0] pid_slots [N_PROC][N_SLOTS];

  request_t request_queue[$];
  reply_t   expected_replies[$];

  int n_requests   = 0;
  int requests_in  = 0;
  int replies_out  = 0;
  int failures     = 0;
  int idle_cycles  = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit req_taken    = 1'b0;
  int status_seen [5];

  function automatic reply_t table_apply_request(input request_t rq);
    reply_t rp;
    int     used;
    int     target;
    bit     placed;
    rp.status = mot_pkg::ST_OK;
    rp.mbx    = '0;
    used      = 0;
    target    = 0;
    placed    = 1'b0;
    if (rq.num >= N_MBX || rq.pid >= N_PROC) begin
      rp.status = mot_pkg::ST_BAD_NUMBER;
      return rp;
    end
    for (int k = 0; k < N_SLOTS; k++)
      if (pid_slots[rq.pid][k] != 0) used++;
    if (rq.kind == KIND_BIND) begin
      if (rq.num == 0) begin
        for (int m = N_MBX - 1; m >= 1; m--)
          if (!own_valid[m]) target = m;
        if (target == 0) begin
          rp.status = mot_pkg::ST_NONE_FREE;
          return rp;
        end
      end else begin
        if (own_valid[rq.num]) begin
          rp.status = mot_pkg::ST_IN_USE;
          return rp;
        end
        target = rq.num;
      end
      if (used >= N_SLOTS) begin
        rp.status = mot_pkg::ST_SLOTS_FULL;
        return rp;
      end
      own_valid[target] = 1'b1;
      own_pid[target]   = rq.pid;
      for (int k = 0; k < N_SLOTS; k++)
        if (!placed && pid_slots[rq.pid][k] == 0) begin
          pid_slots[rq.pid][k] = target[mot_pkg::MBX_W-1:0];
          placed = 1'b1;
        end
      rp.mbx = target[mot_pkg::MBX_W-1:0];
      return rp;
    end
    if (rq.num == 0) begin
      for (int k = 0; k < N_SLOTS; k++) pid_slots[rq.pid][k] = '0;
      for (int m = 1; m < N_MBX; m++)
        if (own_valid[m] && own_pid[m] == rq.pid) begin
          own_valid[m] = 1'b0;
          own_pid[m]   = '0;
        end
      return rp;
    end
    if (!own_valid[rq.num] || own_pid[rq.num] != rq.pid) begin
      rp.status = mot_pkg::ST_IN_USE;
      return rp;
    end
    own_valid[rq.num] = 1'b0;
    own_pid[rq.num]   = '0;
    for (int k = 0; k < N_SLOTS; k++)
      if (!placed && pid_slots[rq.pid][k] == rq.num[mot_pkg::MBX_W-1:0]) begin
        pid_slots[rq.pid][k] = '0;
        placed = 1'b1;
      end
    rp.mbx = rq.num[mot_pkg::MBX_W-1:0];
    return rp;
  endfunction

  task automatic add_request(input logic kind, input int pid, input int num);
    request_t rq;
    rq.kind = kind;
    rq.pid  = pid[mot_pkg::PID_W-1:0];
    rq.num  = num[mot_pkg::NUM_W-1:0];
    request_queue.push_back(rq);
  endtask

  function automatic bit calm_window();
    return requests_in >= 700 && requests_in < 1000;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus
  initial begin
    int recent [N_PROC];
    int sel;
    int base;
    int pid;
    int num;
    int roll;
    for (int m = 0; m < N_MBX; m++) begin
      own_valid[m] = 1'b0;
      own_pid[m]   = '0;
    end
    for (int p = 0; p < N_PROC; p++) begin
      recent[p] = 1;
      for (int k = 0; k < N_SLOTS; k++) pid_slots[p][k] = '0;
    end
    for (int i = 0; i < 5; i++) status_seen[i] = 0;

    // directed: edges of the fields and every status but none-free
    add_request(KIND_UNBIND, 0, 0);      // unbind-all with nothing bound
    add_request(KIND_BIND, 0, 127);      // number out of range
    add_request(KIND_UNBIND, 3, 64);     // out of range on unbind
    add_request(KIND_BIND, 0, 0);        // bind-any gets 1
    add_request(KIND_BIND, 1, 63);
    add_request(KIND_BIND, 1, 63);       // owned by requester
    add_request(KIND_BIND, 2, 63);       // owned by another
    add_request(KIND_UNBIND, 2, 63);     // not owner
    add_request(KIND_UNBIND, 2, 5);      // free mailbox
    for (int n = 2; n <= 5; n++) add_request(KIND_BIND, 0, n);
    add_request(KIND_BIND, 0, 6);        // slots full, named
    add_request(KIND_BIND, 0, 0);        // slots full, any
    add_request(KIND_UNBIND, 0, 3);
    add_request(KIND_BIND, 0, 0);        // reuses hole at 3
    add_request(KIND_UNBIND, 1, 63);
    add_request(KIND_UNBIND, 15, 0);
    add_request(KIND_BIND, 15, 42);
    add_request(KIND_UNBIND, 0, 0);
    add_request(KIND_UNBIND, 15, 0);

    while (request_queue.size() < N_RANDOM + 22) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        // mixed traffic on a few processes over a small number space
        base = $urandom_range(N_PROC - 1);
        for (int i = 0; i < 20; i++) begin
          pid  = (base + $urandom_range(2)) % N_PROC;
          roll = $urandom_range(99);
          if (roll < 15) num = 0;
          else if (roll < 20) num = $urandom_range(127, N_MBX);
          else num = $urandom_range(12, 1);
          if ($urandom_range(1) == 0) begin
            add_request(KIND_BIND, pid, num);
            if (num != 0 && num < N_MBX) recent[pid] = num;
          end else begin
            if (num != 0 && $urandom_range(1) == 0) num = recent[pid];
            add_request(KIND_UNBIND, pid, num);
          end
        end
      end else if (sel < 80) begin
        // fill the table until nothing is free, poke it, then drain
        for (int i = 0; i < N_PROC * N_SLOTS; i++) add_request(KIND_BIND, i % N_PROC, 0);
        for (int i = 0; i < 4; i++) add_request(KIND_BIND, $urandom_range(N_PROC - 1), 0);
        add_request(KIND_BIND, $urandom_range(N_PROC - 1), $urandom_range(N_MBX - 1, 1));
        for (int i = 0; i < 6; i++)
          add_request(KIND_UNBIND, $urandom_range(N_PROC - 1), $urandom_range(N_MBX - 1, 1));
        for (int i = 0; i < 3; i++) add_request(KIND_BIND, $urandom_range(N_PROC - 1), 0);
        for (int p = 0; p < N_PROC; p++)
          if ($urandom_range(9) != 0) add_request(KIND_UNBIND, p, 0);
      end else begin
        for (int i = 0; i < 10; i++)
          add_request(1'($urandom_range(1)), $urandom_range(N_PROC - 1),
                      $urandom_range(127));
      end
    end
    n_requests = request_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (replies_out == n_requests);
    repeat (N_MBX + 8) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0d replies never arrived", expected_replies.size());
      failures++;
    end
    $display("requests: %0d  ok=%0d bad_number=%0d none_free=%0d in_use=%0d slots_full=%0d",
             n_requests, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4]);
    $display("mismatches/unexpected replies: %0d", failures);
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // request driver
  always @(negedge clk) begin : drive
    request_t rq;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (request_queue.size() > 0 && (calm_window() || $urandom_range(99) >= 36)) begin
        rq = request_queue.pop_front();
        s_tdata  <= {5'b0, rq.num, rq.pid};
        s_tuser  <= rq.kind;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // reply receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && requests_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm_window() || $urandom_range(99) >= 36;
    end
  end

  // checker: replies compared first, then the accepted request is predicted
  always @(posedge clk) begin : check
    reply_t   got;
    reply_t   want;
    request_t rq;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.mbx    = m_tdata[8:3];
        replies_out <= replies_out + 1;
        if (expected_replies.size() == 0) begin
          if (failures < 10)
            $display("unexpected reply status=%0d mailbox=%0d", got.status, got.mbx);
          failures <= failures + 1;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.mbx !== want.mbx) begin
            if (failures < 10)
              $display("reply %0d: expected status=%0d mailbox=%0d, got status=%0d mailbox=%0d",
                       replies_out, want.status, want.mbx, got.status, got.mbx);
            failures <= failures + 1;
          end
        end
      end
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        rq.kind = s_tuser;
        rq.pid  = s_tdata[3:0];
        rq.num  = s_tdata[10:4];
        want = table_apply_request(rq);
        status_seen[want.status]++;
        expected_replies.push_back(want);
        requests_in <= requests_in + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
src/mot_pkg.sv
src/mot_owner_mem.sv
src/mot_cmp.sv
src/mailbox_ownership_table_top.sv
verif/tb.sv
